// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/bump_alloc_pkg.sv =====
// Types and constants shared by the bump allocator.
`default_nettype none
package bump_alloc_pkg;
   localparam int ADDR_W   = 17;
   localparam int SIZE_W   = 18;
   localparam int STATUS_W = 3;
   // Width wide enough to compare any stored pool offset with a request address.
   localparam int CMP_W    = 25;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_POOL    = 3'd1,
      ST_TABLE   = 3'd2,
      ST_DOUBLE  = 3'd3,
      ST_UNKNOWN = 3'd4
   } status_type;
endpackage
`default_nettype wire

// ===== rtl/bump_alloc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bump_alloc_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/bump_allocator_exact_size_reuse_unit.sv =====
// Top level of the bump allocator with exact-size reuse of freed blocks.
//
//  channel | direction | transfer when            | payload
//  --------+-----------+--------------------------+---------------------------------------
//  req     | in        | start & !busy            | req_opcode, req_request_size,
//          |           |                          | req_block_address
//  rsp     | out       | rsp_valid (one cycle)    | rsp_result_address, rsp_status
//
// The scan examines entries in order and the response strobe follows the first match; when
// none matches, S_MISS decides the status and, on a successful allocation, appends the entry.
// At most TABLE_ENTRIES entries are examined: the control table sits in one RAM and the
// scan reads one entry per cycle through its single read port.
// busy is high from the cycle after the transfer until the response strobe, which coincides
// with busy falling, so a new request may be given in the same cycle the response appears.
// Reset clears the entry count and pool pointer; no clearing pass is needed because only
// entries below the count are ever read. The response cannot be stalled.
`default_nettype none
`include "assert_macros.svh"
module bump_allocator_exact_size_reuse_unit #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int POOL_BYTES    = 131072
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_opcode,
   input  wire logic [bump_alloc_pkg::SIZE_W-1:0]   req_request_size,
   input  wire logic [bump_alloc_pkg::ADDR_W-1:0]   req_block_address,
   output logic                                     rsp_valid,
   output logic [bump_alloc_pkg::ADDR_W-1:0]        rsp_result_address,
   output logic [bump_alloc_pkg::STATUS_W-1:0]      rsp_status
);
   localparam int IW     = $clog2(TABLE_ENTRIES);
   localparam int CNTW   = $clog2(TABLE_ENTRIES + 1);
   localparam int AW     = $clog2(POOL_BYTES);
   localparam int PW     = $clog2(POOL_BYTES + 1);
   localparam int SW     = bump_alloc_pkg::SIZE_W;
   localparam int EW     = ((PW > SW) ? PW : SW) + 1;
   localparam int WORD_W = AW + SW + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MISS
   } state_type;

   state_type                          state_ff, state_in;
   bump_alloc_pkg::op_type             op_ff, op_in;
   logic [SW-1:0]                      size_ff, size_in;
   logic [bump_alloc_pkg::ADDR_W-1:0]  baddr_ff, baddr_in;
   logic [CNTW-1:0]                    count_ff, count_in;
   logic [PW-1:0]                      ptr_ff, ptr_in;
   logic [CNTW-1:0]                    issue_ff, issue_in;
   logic [IW-1:0]                      chk_ff, chk_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bump_alloc_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   bump_alloc_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic              wr_en, rd_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   logic [AW-1:0] ent_addr;
   logic [SW-1:0] ent_size;
   logic          ent_freed;
   logic          hit;
   logic [EW-1:0] end_sum;
   logic          pool_fail;

   bump_alloc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign {ent_addr, ent_size, ent_freed} = rd_data;

   always_comb begin
      if (op_ff == bump_alloc_pkg::OP_ALLOC) begin
         hit = ent_freed && (ent_size == size_ff);
      end else begin
         hit = (bump_alloc_pkg::CMP_W'(ent_addr) == bump_alloc_pkg::CMP_W'(baddr_ff));
      end
   end

   assign end_sum   = EW'(ptr_ff) + EW'(size_ff);
   assign pool_fail = (end_sum > EW'(POOL_BYTES)) || (EW'(ptr_ff) >= EW'(POOL_BYTES));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      baddr_in      = baddr_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      issue_in      = issue_ff;
      chk_in        = chk_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = '0;
      rsp_status_in = bump_alloc_pkg::ST_OK;
      wr_en         = 1'b0;
      wr_addr       = chk_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = bump_alloc_pkg::op_type'(req_opcode);
               size_in  = req_request_size;
               baddr_in = req_block_address;
               if (count_ff == '0) begin
                  state_in = S_MISS;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  chk_in   = '0;
                  issue_in = CNTW'(1);
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == bump_alloc_pkg::OP_ALLOC) begin
                  wr_en       = 1'b1;
                  wr_data     = {ent_addr, ent_size, 1'b0};
                  rsp_addr_in = bump_alloc_pkg::ADDR_W'(ent_addr);
               end else if (ent_freed) begin
                  rsp_status_in = bump_alloc_pkg::ST_DOUBLE;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = {ent_addr, ent_size, 1'b1};
               end
            end else if (issue_ff == count_ff) begin
               state_in = S_MISS;
            end else begin
               rd_en    = 1'b1;
               chk_in   = issue_ff[IW-1:0];
               issue_in = issue_ff + CNTW'(1);
            end
         end
         S_MISS: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (op_ff == bump_alloc_pkg::OP_FREE) begin
               rsp_status_in = bump_alloc_pkg::ST_UNKNOWN;
            end else if (pool_fail) begin
               rsp_status_in = bump_alloc_pkg::ST_POOL;
            end else if (count_ff == CNTW'(TABLE_ENTRIES)) begin
               rsp_status_in = bump_alloc_pkg::ST_TABLE;
            end else begin
               // Append a new entry at the end of the table and bump the pointer.
               wr_en       = 1'b1;
               wr_addr     = count_ff[IW-1:0];
               wr_data     = {AW'(ptr_ff), size_ff, 1'b0};
               rsp_addr_in = bump_alloc_pkg::ADDR_W'(ptr_ff);
               count_in    = count_ff + CNTW'(1);
               ptr_in      = PW'(end_sum);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      size_ff       <= size_in;
      baddr_ff      <= baddr_in;
      chk_ff        <= chk_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

   `ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   `ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNTW'(TABLE_ENTRIES))
   `ASSERT_IMPLY(a_ptr_bound, clock, reset, 1'b1, EW'(ptr_ff) <= EW'(POOL_BYTES))
   `ASSERT_IMPLY(a_scan_in_table, clock, reset, state_ff == S_SCAN,
                 (issue_ff <= count_ff) && (issue_ff != '0))
   `ASSERT_IMPLY(a_error_zero_addr, clock, reset,
                 rsp_valid_ff && (rsp_status_ff != bump_alloc_pkg::ST_OK), rsp_addr_ff == '0)
endmodule
`default_nettype wire
